>>> rtl/core/tspb_pkg.sv
package tspb_pkg;

  localparam int CFG_BITS  = 12;
  localparam int CHAN_BITS = 4;
  localparam int IDX_BITS  = 2;
  localparam int SCALE_SHIFT = 14;
  localparam int CODE_BITS = 14;
  localparam int QUEUE_DEPTH = 2;
  localparam int SAMPLE_BITS_DEF = 12;

  localparam logic [IDX_BITS-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [IDX_BITS-1:0] CFG_SPAN      = 2'd1;
  localparam logic [IDX_BITS-1:0] CFG_CHANNEL   = 2'd2;

  localparam logic [CFG_BITS-1:0]  THRESHOLD_RST = 12'd3276;
  localparam logic [CFG_BITS-1:0]  SPAN_RST      = 12'd2670;
  localparam logic [CHAN_BITS-1:0] CHANNEL_RST   = 4'd0;

  localparam logic [CODE_BITS-1:0] BEND_CENTRE = 14'h2000;
  localparam logic [CODE_BITS-1:0] CODE_MAX    = 14'h3fff;
  localparam int BEND_MAX = 8191;
  localparam int BEND_MIN_MAG = 8192;
  localparam logic [7:0] STATUS_PB = 8'he0;

  localparam logic [1:0] BYTE_STATUS = 2'd0;
  localparam logic [1:0] BYTE_LSB    = 2'd1;
  localparam logic [1:0] BYTE_MSB    = 2'd2;

  typedef struct packed {
    logic [CFG_BITS-1:0]  threshold;
    logic [CFG_BITS-1:0]  span;
    logic [CHAN_BITS-1:0] channel;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SAT,
    BK_SEND
  } bk_state_t;

endpackage

>>> rtl/core/tspb_fifo.sv
module tspb_fifo import tspb_pkg::*; #(
  parameter int W     = 14,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/core/tspb_front.sv
module tspb_front import tspb_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic [SAMPLE_BITS-1:0] in_capture_sample,
  input  logic                   q_full,
  output logic                   push,
  output logic [SAMPLE_BITS+1:0] push_data
);

  localparam int CW = (SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS;

  logic                   active_r, active_nxt;
  logic [SAMPLE_BITS-1:0] start_r, start_nxt;
  logic [CW-1:0]          s_ext, thr_ext;
  logic                   below, above, neg, zero;
  logic [SAMPLE_BITS-1:0] mag;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign s_ext    = CW'(in_sample);
  assign thr_ext  = CW'(cfg.threshold);
  assign below    = s_ext < thr_ext;
  assign above    = s_ext > thr_ext;
  assign neg      = in_sample < start_r;
  assign mag      = neg ? (start_r - in_sample) : (in_sample - start_r);

  always_comb begin
    active_nxt = active_r;
    start_nxt  = start_r;
    zero       = 1'b1;
    if (!active_r) begin
      if (below) begin
        active_nxt = 1'b1;
        start_nxt  = in_capture_sample;
      end
    end else if (above) begin
      active_nxt = 1'b0;
    end else begin
      zero = 1'b0;
    end
  end

  assign push_data = {zero, neg, mag};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      start_r  <= '0;
    end else if (push) begin
      active_r <= active_nxt;
      start_r  <= start_nxt;
    end
  end

endmodule

>>> rtl/core/tspb_back.sv
module tspb_back import tspb_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   q_empty,
  input  logic [SAMPLE_BITS+1:0] pop_data,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_last_byte
);

  localparam int DW   = SAMPLE_BITS + SCALE_SHIFT;
  localparam int CNTW = $clog2(DW + 1);

  bk_state_t               state_r, state_nxt;
  logic [DW-1:0]           quo_r, quo_nxt;
  logic [CFG_BITS-1:0]     rem_r, rem_nxt;
  logic [CNTW-1:0]         cnt_r, cnt_nxt;
  logic                    neg_r, neg_nxt;
  logic [CODE_BITS-1:0]    code_r, code_nxt;
  logic [1:0]              idx_r, idx_nxt;
  logic [CFG_BITS-1:0]     span_eff;
  logic [CFG_BITS:0]       shifted, trial;
  logic                    fits;
  logic                    j_zero, j_neg;
  logic [SAMPLE_BITS-1:0]  j_mag;

  assign span_eff = (cfg.span == '0) ? CFG_BITS'(1) : cfg.span;
  assign shifted  = {rem_r, quo_r[DW-1]};
  assign fits     = shifted >= {1'b0, span_eff};
  assign trial    = shifted - {1'b0, span_eff};
  assign {j_zero, j_neg, j_mag} = pop_data;

  always_comb begin
    state_nxt = state_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    code_nxt  = code_r;
    idx_nxt   = idx_r;
    pop       = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          pop     = 1'b1;
          neg_nxt = j_neg;
          idx_nxt = BYTE_STATUS;
          if (j_zero) begin
            code_nxt  = BEND_CENTRE;
            state_nxt = BK_SEND;
          end else begin
            quo_nxt   = {j_mag, SCALE_SHIFT'(0)};
            rem_nxt   = '0;
            cnt_nxt   = CNTW'(DW);
            state_nxt = BK_DIV;
          end
        end
      end
      BK_DIV: begin
        rem_nxt = fits ? trial[CFG_BITS-1:0] : shifted[CFG_BITS-1:0];
        quo_nxt = {quo_r[DW-2:0], fits};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          state_nxt = BK_SAT;
        end
      end
      BK_SAT: begin
        if (!neg_r) begin
          code_nxt = (quo_r >= DW'(BEND_MAX)) ? CODE_MAX
                                              : BEND_CENTRE + quo_r[CODE_BITS-1:0];
        end else begin
          code_nxt = (quo_r >= DW'(BEND_MIN_MAG)) ? '0
                                                  : BEND_CENTRE - quo_r[CODE_BITS-1:0];
        end
        state_nxt = BK_SEND;
      end
      BK_SEND: begin
        if (out_ready) begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r == BYTE_MSB) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      idx_r   <= BYTE_STATUS;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    neg_r  <= neg_nxt;
    code_r <= code_nxt;
  end

  assign out_valid     = (state_r == BK_SEND);
  assign out_last_byte = (idx_r == BYTE_MSB);

  always_comb begin
    unique case (idx_r)
      BYTE_STATUS: out_byte = STATUS_PB | {4'b0, cfg.channel};
      BYTE_LSB:    out_byte = {1'b0, code_r[6:0]};
      BYTE_MSB:    out_byte = {1'b0, code_r[13:7]};
      default:     out_byte = '0;
    endcase
  end

endmodule

>>> rtl/core/touch_strip_pitch_bend_encoder_top.sv
// Touch-strip pitch bend encoder. Every accepted poll tick produces one three-byte
// pitch bend message (status, low 7 bits, high 7 bits; out_last_byte marks the
// third). The front end tracks the touch state and queues a job in a two-entry
// queue; the back end runs a restoring divider, one quotient bit per cycle. An active
// tick's job is taken from the queue, divided, saturated and sent as three bytes;
// an idle, arm or release tick skips the division and saturation. Configuration
// writes are registered, with no read-back.
module touch_strip_pitch_bend_encoder_top import tspb_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic [SAMPLE_BITS-1:0] in_capture_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_last_byte,
  input  logic                   cfg_we,
  input  logic [IDX_BITS-1:0]    cfg_index,
  input  logic [CFG_BITS-1:0]    cfg_data
);

  localparam int JW = SAMPLE_BITS + 2;

  cfg_t          cfg_r;
  logic          push, pop, q_full, q_empty;
  logic [JW-1:0] push_data, pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold <= THRESHOLD_RST;
      cfg_r.span      <= SPAN_RST;
      cfg_r.channel   <= CHANNEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD: cfg_r.threshold <= cfg_data;
        CFG_SPAN:      cfg_r.span      <= cfg_data;
        CFG_CHANNEL:   cfg_r.channel   <= cfg_data[CHAN_BITS-1:0];
        default:       ;
      endcase
    end
  end

  tspb_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .in_capture_sample (in_capture_sample),
    .q_full            (q_full),
    .push              (push),
    .push_data         (push_data)
  );

  tspb_fifo #(
    .W     (JW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  tspb_back #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_empty       (q_empty),
    .pop_data      (pop_data),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

endmodule
